>>> design/lers_pkg.sv
// Package for the lane edge row scanner: row width, register reset values,
// register addresses and the packed word types of both channels.
// No dependencies; every other design file imports it.
package lers_pkg;

   localparam int ROW_WIDTH = 188;

   localparam logic [7:0] ROW_WIDTH_B         = 8'(ROW_WIDTH);
   localparam logic [7:0] LAST_RIGHT_COLUMN_B = 8'(ROW_WIDTH - 1);
   localparam logic [7:0] DARK_THRESHOLD_RESET = 8'd128;
   localparam logic [7:0] START_COLUMN_RESET   = 8'd94;
   localparam logic [7:0] COLUMN_COUNT_MAX     = 8'd255;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic {
      CSR_DARK_THRESHOLD = 1'b0,
      CSR_START_COLUMN   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] grey_value;
      logic       row_end;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      logic [7:0] left_edge;
      logic [7:0] right_edge;
      logic [7:0] middle_column;
      logic       left_found;
      logic       right_found;
      logic       frame_last;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] dark_threshold;
      logic [7:0] start_column;
   } cfg_type;

endpackage

>>> design/lers_csr.sv
// Configuration registers of the lane edge row scanner behind an APB-style port.
// Depends on lers_pkg for the reset values, the address map and cfg_type.
module lers_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lers_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [lers_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [lers_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output lers_pkg::cfg_type                      cfg
);
   import lers_pkg::*;

   logic [7:0]    dark_threshold_ff, dark_threshold_in;
   logic [7:0]    start_column_ff, start_column_in;
   csr_index_type index;
   logic          write_strobe;

   // The register index is the word address; the byte offset bits are ignored.
   assign index        = csr_index_type'(csr_paddr[2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready   = 1'b1;

   always_comb begin
      dark_threshold_in = dark_threshold_ff;
      start_column_in   = start_column_ff;
      csr_prdata        = '0;
      unique case (index)
         CSR_DARK_THRESHOLD: begin
            csr_prdata = CSR_DATA_WIDTH'(dark_threshold_ff);
            if (write_strobe) begin
               dark_threshold_in = csr_pwdata[7:0];
            end
         end
         CSR_START_COLUMN: begin
            csr_prdata = CSR_DATA_WIDTH'(start_column_ff);
            if (write_strobe) begin
               start_column_in = csr_pwdata[7:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff <= DARK_THRESHOLD_RESET;
         start_column_ff   <= START_COLUMN_RESET;
      end else begin
         dark_threshold_ff <= dark_threshold_in;
         start_column_ff   <= start_column_in;
      end
   end

   assign cfg.dark_threshold = dark_threshold_ff;
   assign cfg.start_column   = start_column_ff;

endmodule

>>> design/lers_scan.sv
// Row scan core: binarizes one pixel, runs the edge tests on the two-pixel
// window and forms the row result. Depends on lers_pkg for types and constants.
module lers_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  lers_pkg::req_word_type  pixel,
   input  lers_pkg::cfg_type       cfg,
   output logic                    has_result,
   output lers_pkg::rsp_word_type  result
);
   import lers_pkg::*;

   logic [7:0] column_count_ff, column_count_in;
   logic [1:0] pixel_window_ff, pixel_window_in;
   logic [7:0] scan_start_ff, scan_start_in;
   logic [7:0] right_hit_ff, right_hit_in;
   logic       right_hit_valid_ff, right_hit_valid_in;
   logic [7:0] left_hit_ff, left_hit_in;
   logic       left_hit_valid_ff, left_hit_valid_in;

   logic       dark;
   logic [7:0] tested_column;
   logic       in_row;
   logic       right_match;
   logic       left_match;
   logic [7:0] left_value;
   logic [7:0] right_value;
   logic [8:0] edge_sum;

   assign dark          = (pixel.grey_value <= cfg.dark_threshold);
   // The window holds the two pixels before this one, so the candidate is one back.
   assign tested_column = column_count_ff - 8'd1;
   assign in_row        = (column_count_ff < ROW_WIDTH_B);

   assign right_match = in_row && (column_count_ff >= 8'd2) && !right_hit_valid_ff
                        && (tested_column >= scan_start_ff)
                        && (tested_column < LAST_RIGHT_COLUMN_B)
                        && pixel_window_ff[0] && !pixel_window_ff[1] && dark;

   assign left_match  = in_row && (column_count_ff >= 8'd3)
                        && (tested_column <= scan_start_ff)
                        && pixel_window_ff[0] && pixel_window_ff[1] && !dark;

   assign has_result  = pixel.row_end || pixel.frame_end;

   // The row result includes a match made on this very pixel.
   always_comb begin
      left_value  = left_match ? tested_column :
                    (left_hit_valid_ff ? left_hit_ff : 8'd0);
      right_value = right_match ? tested_column :
                    (right_hit_valid_ff ? right_hit_ff : ROW_WIDTH_B);
      edge_sum    = {1'b0, left_value} + {1'b0, right_value};

      result.left_edge     = left_value;
      result.right_edge    = right_value;
      result.middle_column = edge_sum[8:1];
      result.left_found    = left_match || left_hit_valid_ff;
      result.right_found   = right_match || right_hit_valid_ff;
      result.frame_last    = pixel.frame_end;
   end

   always_comb begin
      column_count_in    = column_count_ff;
      pixel_window_in    = pixel_window_ff;
      scan_start_in      = scan_start_ff;
      right_hit_in       = right_hit_ff;
      right_hit_valid_in = right_hit_valid_ff;
      left_hit_in        = left_hit_ff;
      left_hit_valid_in  = left_hit_valid_ff;
      if (step) begin
         if (has_result) begin
            column_count_in    = 8'd0;
            pixel_window_in    = 2'b00;
            right_hit_in       = ROW_WIDTH_B;
            right_hit_valid_in = 1'b0;
            left_hit_in        = 8'd0;
            left_hit_valid_in  = 1'b0;
            scan_start_in      = pixel.frame_end ? cfg.start_column : edge_sum[8:1];
         end else begin
            if (column_count_ff != COLUMN_COUNT_MAX) begin
               column_count_in = column_count_ff + 8'd1;
            end
            if (in_row) begin
               pixel_window_in = {pixel_window_ff[0], dark};
            end
            if (right_match) begin
               right_hit_in       = tested_column;
               right_hit_valid_in = 1'b1;
            end
            if (left_match) begin
               left_hit_in       = tested_column;
               left_hit_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff    <= 8'd0;
         pixel_window_ff    <= 2'b00;
         scan_start_ff      <= START_COLUMN_RESET;
         right_hit_ff       <= ROW_WIDTH_B;
         right_hit_valid_ff <= 1'b0;
         left_hit_ff        <= 8'd0;
         left_hit_valid_ff  <= 1'b0;
      end else begin
         column_count_ff    <= column_count_in;
         pixel_window_ff    <= pixel_window_in;
         scan_start_ff      <= scan_start_in;
         right_hit_ff       <= right_hit_in;
         right_hit_valid_ff <= right_hit_valid_in;
         left_hit_ff        <= left_hit_in;
         left_hit_valid_ff  <= left_hit_valid_in;
      end
   end

endmodule

>>> design/lane_edge_row_scanner_top.sv
// Top level of the lane edge row scanner: pixel input register, scan core,
// result register and configuration registers. Depends on lers_pkg,
// lers_csr and lers_scan.
//
//   Channel   Ports           Direction  Word
//   --------  --------------  ---------  ---------------------------------------
//   req       req_valid/ready in         grey_value, row_end, frame_end
//   rsp       rsp_valid/ready out        left/right/middle, found flags, frame_last
//   csr       csr_p*          in/out     dark_threshold (0x0), start_column (0x4)
//
// One pixel word is accepted per clock cycle while no row end waits on the result
// register; the scan core's per-pixel work is combinational between the input
// and result registers. A row result is registered as its last pixel advances.
// Reset is synchronous; it empties both registers, clears the row state and loads
// the scan start with the reset start column. A stall on rsp holds the row result,
// and pixels that close no row keep flowing past it until a second row end needs
// the result register.
module lane_edge_row_scanner_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  lers_pkg::req_word_type                 req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output lers_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [lers_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [lers_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [lers_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import lers_pkg::*;

   cfg_type      cfg;
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         has_result;
   rsp_word_type result;
   logic         out_free;
   logic         advance;

   lers_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lers_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .pixel      (in_word_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   // The result register is free when empty or being read this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // A registered pixel moves on unless it closes a row and the result has nowhere to go.
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid bits guard them.
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
